// ===== rtl/core/bpg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpg_pkg: shared types and constants
// Transfer formats, configuration bundle and fixed values of the beep
// pattern generator.
// ----------------------------------------------------------------------------
package bpg_pkg;

  localparam int unsigned ApbAddrBits = 3;
  localparam int unsigned ApbDataBits = 32;

  localparam logic REG_ENABLE  = 1'b0;
  localparam logic REG_LOCKOUT = 1'b1;

  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_START = 1'b1;

  localparam logic [7:0] LOCKOUT_RESET    = 8'd100;
  localparam logic [7:0] SINCE_MAX        = 8'hFF;
  localparam int unsigned DefaultDuration = 80;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  beep_count;
    logic [15:0] on_time_ms;
    logic [15:0] off_time_ms;
  } in_item_t;

  typedef struct packed {
    logic buzzer_level;
    logic pattern_active;
    logic start_accepted;
  } out_item_t;

  typedef struct packed {
    logic       enable;
    logic [7:0] lockout_ms;
    logic       clear;
  } cfg_t;

endpackage

// ===== rtl/core/bpg_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpg_cfg: configuration registers
// APB-style register file holding the enable and the start lockout time.
// Raises a one-cycle clear when the enable is written to zero.
// ----------------------------------------------------------------------------
module bpg_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [bpg_pkg::ApbAddrBits-1:0]      paddr,
  input  logic [bpg_pkg::ApbDataBits-1:0]      pwdata,
  output logic [bpg_pkg::ApbDataBits-1:0]      prdata,
  output logic                                 pready,
  output bpg_pkg::cfg_t                        cfg_o
);

  logic       enable_q, enable_d;
  logic [7:0] lockout_q, lockout_d;
  logic       wr_en;
  logic       reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  always_comb begin
    enable_d  = enable_q;
    lockout_d = lockout_q;
    if (wr_en) begin
      unique case (reg_sel)
        bpg_pkg::REG_ENABLE:  enable_d  = pwdata[0];
        bpg_pkg::REG_LOCKOUT: lockout_d = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b0;
      lockout_q <= bpg_pkg::LOCKOUT_RESET;
    end else begin
      enable_q  <= enable_d;
      lockout_q <= lockout_d;
    end
  end

  always_comb begin
    unique case (reg_sel)
      bpg_pkg::REG_ENABLE:  prdata = {{(bpg_pkg::ApbDataBits-1){1'b0}}, enable_q};
      bpg_pkg::REG_LOCKOUT: prdata = {{(bpg_pkg::ApbDataBits-8){1'b0}}, lockout_q};
      default:              prdata = '0;
    endcase
  end

  assign cfg_o.enable     = enable_q;
  assign cfg_o.lockout_ms = lockout_q;
  assign cfg_o.clear      = wr_en & (reg_sel == bpg_pkg::REG_ENABLE) & ~pwdata[0];

endmodule

// ===== rtl/core/bpg_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpg_engine: pattern state and single-pass update
// Holds the beep counter, phase, phase timer, lockout counter and held
// durations, and computes one result per item from the current state.
// ----------------------------------------------------------------------------
module bpg_engine #(
  parameter int unsigned DURATION_BITS = 16,
  parameter int unsigned COUNT_BITS    = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bpg_pkg::cfg_t      cfg_i,
  input  logic               fire_i,
  input  bpg_pkg::in_item_t  item_i,
  output bpg_pkg::out_item_t result_o
);

  logic [COUNT_BITS-1:0]    beeps_q, beeps_d;
  logic                     phase_on_q, phase_on_d;
  logic [DURATION_BITS-1:0] wait_q, wait_d;
  logic [7:0]               since_q, since_d;
  logic [DURATION_BITS-1:0] held_on_q, held_on_d;
  logic [DURATION_BITS-1:0] held_off_q, held_off_d;

  logic [COUNT_BITS-1:0]    req_count;
  logic [DURATION_BITS-1:0] req_on;
  logic [DURATION_BITS-1:0] req_off;
  logic [DURATION_BITS-1:0] wait_dec;
  logic [COUNT_BITS-1:0]    beeps_dec;
  logic                     accepted;

  assign req_count = COUNT_BITS'(item_i.beep_count);
  assign req_on    = DURATION_BITS'(item_i.on_time_ms);
  assign req_off   = DURATION_BITS'(item_i.off_time_ms);
  assign wait_dec  = (wait_q != '0) ? wait_q - DURATION_BITS'(1) : '0;
  assign beeps_dec = beeps_q - COUNT_BITS'(1);

  always_comb begin
    beeps_d    = beeps_q;
    phase_on_d = phase_on_q;
    wait_d     = wait_q;
    since_d    = since_q;
    held_on_d  = held_on_q;
    held_off_d = held_off_q;
    accepted   = 1'b0;
    if (cfg_i.clear) begin
      beeps_d    = '0;
      phase_on_d = 1'b0;
      wait_d     = '0;
    end else if (fire_i) begin
      if (item_i.req_type == bpg_pkg::REQ_TICK) begin
        if (since_q != bpg_pkg::SINCE_MAX) begin
          since_d = since_q + 8'd1;
        end
        if (cfg_i.enable && (beeps_q != '0)) begin
          if (wait_dec != '0) begin
            wait_d = wait_dec;
          end else if (phase_on_q) begin
            phase_on_d = 1'b0;
            beeps_d    = beeps_dec;
            wait_d     = (beeps_dec != '0) ? held_off_q : '0;
          end else begin
            phase_on_d = 1'b1;
            wait_d     = held_on_q;
          end
        end
      end else if (cfg_i.enable && (req_count != '0) && (since_q >= cfg_i.lockout_ms)) begin
        accepted   = 1'b1;
        since_d    = '0;
        held_on_d  = req_on;
        held_off_d = req_off;
        beeps_d    = req_count;
        phase_on_d = 1'b0;
        wait_d     = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beeps_q    <= '0;
      phase_on_q <= 1'b0;
      wait_q     <= '0;
      since_q    <= '0;
      held_on_q  <= DURATION_BITS'(bpg_pkg::DefaultDuration);
      held_off_q <= DURATION_BITS'(bpg_pkg::DefaultDuration);
    end else begin
      beeps_q    <= beeps_d;
      phase_on_q <= phase_on_d;
      wait_q     <= wait_d;
      since_q    <= since_d;
      held_on_q  <= held_on_d;
      held_off_q <= held_off_d;
    end
  end

  assign result_o.buzzer_level   = phase_on_d;
  assign result_o.pattern_active = (beeps_d != '0);
  assign result_o.start_accepted = accepted;

endmodule

// ===== rtl/core/beep_pattern_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beep_pattern_generator: buzzer beep pattern generator
// Takes millisecond ticks and start requests, drives the buzzer level and
// returns one result transfer per input transfer.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_stall_o    in_item_i  (in_item_t)
//   out      output     out_valid_o / out_stall_i  out_item_o (out_item_t)
//   config   input      APB write/read             paddr, pwdata, prdata
//
// An input transfer lands in the input register, and its result is then
// written to the output register; one item per cycle while out_stall_i is low.
// The state update sits between the input register and the output register.
// A stalled result holds the output register; the input register still
// takes one more transfer, after which in_stall_o follows out_stall_i.
// Reset clears both valid flags and the pattern state; no clearing pass.
// ----------------------------------------------------------------------------
module beep_pattern_generator #(
  parameter int unsigned DURATION_BITS = 16,
  parameter int unsigned COUNT_BITS    = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  bpg_pkg::in_item_t               in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output bpg_pkg::out_item_t              out_item_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bpg_pkg::ApbAddrBits-1:0] paddr,
  input  logic [bpg_pkg::ApbDataBits-1:0] pwdata,
  output logic [bpg_pkg::ApbDataBits-1:0] prdata,
  output logic                            pready
);

  bpg_pkg::cfg_t      cfg;
  bpg_pkg::in_item_t  s1_item_q;
  logic               s1_valid_q, s1_valid_d;
  bpg_pkg::out_item_t out_item_q;
  bpg_pkg::out_item_t result;
  logic               out_valid_q, out_valid_d;
  logic               advance;
  logic               load_s1;

  bpg_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign advance    = s1_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = s1_valid_q & ~advance;
  assign load_s1    = in_valid_i & ~in_stall_o;

  bpg_engine #(
    .DURATION_BITS (DURATION_BITS),
    .COUNT_BITS    (COUNT_BITS)
  ) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .fire_i   (advance),
    .item_i   (s1_item_q),
    .result_o (result)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (advance) begin
      s1_valid_d = 1'b0;
    end
    if (load_s1) begin
      s1_valid_d = 1'b1;
    end
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_s1) begin
      s1_item_q <= in_item_i;
    end
    if (advance) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
